/* rtl/core/tlpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int unsigned PoolTablesDefault = 16;
  localparam int unsigned EntryCount        = 1024;
  localparam int unsigned IdxW              = 10;

  localparam logic [1:0] OpMap       = 2'd0;
  localparam logic [1:0] OpUnmap     = 2'd1;
  localparam logic [1:0] OpTranslate = 2'd2;
  localparam logic [1:0] OpCheck     = 2'd3;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StDirAbsent = 3'd1;
  localparam logic [2:0] StPgAbsent  = 3'd2;
  localparam logic [2:0] StPoolEmpty = 3'd3;
  localparam logic [2:0] StNotUser   = 3'd4;
  localparam logic [2:0] StWraps     = 3'd5;

  localparam int unsigned FlagPresent  = 0;
  localparam int unsigned FlagWritable = 1;
  localparam int unsigned FlagUser     = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
    logic [31:0] range_length;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] phys_result;
  } rsp_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]  operation;
    logic        zero_len;   // range check with nothing to walk
    logic        wraps;      // range passes top of space
    logic [19:0] first_page;
    logic [19:0] last_page;
    logic [31:0] entry;      // new table entry for map
    logic        user;       // user bit for new directory entry
    logic [11:0] low;
  } cmd_t;

endpackage

/* rtl/core/tlpt_front.sv */
// ----------------------------------------------------------------------------
// tlpt_front
// Accepts request beats, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module tlpt_front import tlpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  req_t  req_i,
  output logic  cmd_valid_o,
  input  logic  cmd_take_i,
  output cmd_t  cmd_o
);

  localparam int unsigned Depth = 2;

  cmd_t       fifo_q [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_n;
  logic [32:0] end_ex;
  logic [31:0] last_addr;

  // classification
  always_comb begin
    end_ex    = {1'b0, req_i.virt_addr} + {1'b0, req_i.range_length};
    last_addr = end_ex[31:0] - 32'd1;
    cmd_n.operation  = req_i.operation;
    cmd_n.zero_len   = (req_i.range_length == 32'd0);
    cmd_n.wraps      = (end_ex > 33'h1_0000_0000);
    cmd_n.first_page = req_i.virt_addr[31:12];
    cmd_n.last_page  = last_addr[31:12];
    cmd_n.entry      = {req_i.phys_addr[31:12], req_i.page_flags};
    cmd_n.user       = req_i.page_flags[FlagUser];
    cmd_n.low        = req_i.virt_addr[11:0];
  end

  assign full_o      = (cnt_q == 2'(Depth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];

  // command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= ~wr_q;
      end
      if (cmd_take_i && cmd_valid_o) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(cmd_take_i && cmd_valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      fifo_q[wr_q] <= cmd_n;
    end
  end

endmodule

/* rtl/core/tlpt_back.sv */
// ----------------------------------------------------------------------------
// tlpt_back
// Walks the directory and table memories, clears new tables, builds results.
// ----------------------------------------------------------------------------
module tlpt_back import tlpt_pkg::*; #(
  parameter int unsigned PoolTables = PoolTablesDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  output logic  cmd_take_o,
  input  cmd_t  cmd_i,
  output logic  empty_o,
  input  logic  pop_i,
  output rsp_t  rsp_o
);

  localparam int unsigned TblW  = (PoolTables > 1) ? $clog2(PoolTables) : 1;
  localparam int unsigned CntW  = $clog2(PoolTables + 1);
  localparam int unsigned PoolW = TblW + IdxW;

  typedef enum logic [3:0] {
    SInit, SIdle, SDirRd, SDirWait, SDirChk, SClear, STblRd, STblWait, STblChk,
    SDone
  } state_e;

  state_e       state_q;
  logic [31:0]  dir_mem [EntryCount];
  logic [31:0]  pool_mem [PoolTables * EntryCount];
  logic [31:0]  dir_rd_q, pool_rd_q;
  logic [IdxW-1:0] clr_q;     // sweep index for reset clear and table clear
  cmd_t         cmd_q;
  logic [19:0]  page_q;
  logic [TblW-1:0] tbl_q;
  logic [CntW-1:0] next_q;
  logic         full_q;
  rsp_t         rsp_q;
  logic         dir_ok;

  assign cmd_take_o = (state_q == SIdle) && !full_q;
  assign empty_o    = !full_q;
  assign rsp_o      = rsp_q;
  assign dir_ok     = dir_rd_q[FlagPresent] &&
                      ({12'd0, dir_rd_q[31:12]} < 32'(PoolTables));

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      clr_q   <= '0;
      next_q  <= '0;
      full_q  <= 1'b0;
      cmd_q   <= '0;
      page_q  <= '0;
      tbl_q   <= '0;
      rsp_q   <= '0;
    end else begin
      if (pop_i && full_q) begin
        full_q <= 1'b0;
      end
      case (state_q)
        SInit: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(EntryCount - 1)) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (cmd_valid_i && !full_q) begin
            cmd_q  <= cmd_i;
            page_q <= cmd_i.first_page;
            if (cmd_i.operation == OpCheck && (cmd_i.zero_len || cmd_i.wraps)) begin
              rsp_q.status      <= cmd_i.zero_len ? StOk : StWraps;
              rsp_q.phys_result <= '0;
              state_q           <= SDone;
            end else begin
              state_q <= SDirRd;
            end
          end
        end
        SDirRd:   state_q <= SDirWait;
        SDirWait: state_q <= SDirChk;
        SDirChk: begin
          rsp_q.phys_result <= '0;
          rsp_q.status      <= StOk;
          tbl_q             <= TblW'(dir_rd_q[31:12]);
          if (!dir_ok) begin
            if (cmd_q.operation == OpMap) begin
              if (next_q >= CntW'(PoolTables)) begin
                rsp_q.status <= StPoolEmpty;
                state_q      <= SDone;
              end else begin
                tbl_q   <= TblW'(next_q);
                next_q  <= next_q + 1'b1;
                clr_q   <= '0;
                state_q <= SClear;
              end
            end else begin
              rsp_q.status <= StDirAbsent;
              state_q      <= SDone;
            end
          end else begin
            state_q <= STblRd;
          end
        end
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(EntryCount - 1)) begin
            state_q <= STblRd;
          end
        end
        STblRd:   state_q <= STblWait;
        STblWait: state_q <= STblChk;
        STblChk: begin
          case (cmd_q.operation)
            OpMap, OpUnmap: state_q <= SDone;
            OpTranslate: begin
              if (!pool_rd_q[FlagPresent]) begin
                rsp_q.status <= StPgAbsent;
              end else begin
                rsp_q.phys_result <= {pool_rd_q[31:12], cmd_q.low};
              end
              state_q <= SDone;
            end
            default: begin
              if (!pool_rd_q[FlagPresent]) begin
                rsp_q.status <= StPgAbsent;
                state_q      <= SDone;
              end else if (!pool_rd_q[FlagUser]) begin
                rsp_q.status <= StNotUser;
                state_q      <= SDone;
              end else if (page_q == cmd_q.last_page) begin
                state_q <= SDone;
              end else begin
                page_q  <= page_q + 20'd1;
                state_q <= SDirRd;
              end
            end
          endcase
        end
        SDone: begin
          full_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // directory memory: sweep clear, fill on new table, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == SInit) begin
      dir_mem[clr_q] <= '0;
    end else if (state_q == SDirChk && !dir_ok && cmd_q.operation == OpMap &&
                 next_q < CntW'(PoolTables)) begin
      dir_mem[page_q[19:10]] <= {(20-CntW)'(0), next_q, 9'd0,
                                 cmd_q.user, 1'b1, 1'b1};
    end
    if (state_q == SDirRd) begin
      dir_rd_q <= dir_mem[page_q[19:10]];
    end
  end

  // table pool memory
  always_ff @(posedge clk_i) begin
    if (state_q == SClear) begin
      pool_mem[PoolW'({tbl_q, clr_q})] <= '0;
    end else if (state_q == STblChk && cmd_q.operation == OpMap) begin
      pool_mem[PoolW'({tbl_q, page_q[9:0]})] <= cmd_q.entry;
    end else if (state_q == STblChk && cmd_q.operation == OpUnmap) begin
      pool_mem[PoolW'({tbl_q, page_q[9:0]})] <= '0;
    end
    if (state_q == STblRd) begin
      pool_rd_q <= pool_mem[PoolW'({tbl_q, page_q[9:0]})];
    end
  end

endmodule

/* rtl/core/two_level_page_table_engine_core.sv */
// Map, unmap and translate read the directory entry, then the table entry, and
// end early if the directory entry is absent or the pool is used up; a map that
// opens a new table clears it first. A range check that is empty or wrapping ends
// at once, else it walks page by page. The next command starts only after the
// result beat is popped. After reset a directory clear runs before the back end
// takes its first command; the two-entry command queue accepts beats meanwhile.
// ----------------------------------------------------------------------------
// two_level_page_table_engine_core
// Top level: front classifier, command queue and table walk back end.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_core import tlpt_pkg::*; #(
  parameter int unsigned PoolTables = PoolTablesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output rsp_t rsp_o
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  tlpt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  tlpt_back #(.PoolTables(PoolTables)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd), .empty_o(empty), .pop_i(pop), .rsp_o
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Queue-level test of the two-level page table engine core. A scoreboard keeps
// its own directory and table pool and predicts status and physical address
// for each accepted request. Results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  import tlpt_pkg::*;

  localparam int unsigned NumRandom = 1950;
  localparam int unsigned WdLimit   = 300000;
  localparam int unsigned NumHot    = 20;

  // page table shadow and expected response store
  class pt_scoreboard;
    logic [31:0] dir_q [EntryCount];
    logic [31:0] pool_q [int unsigned];
    int unsigned tables_used;
    rsp_t        want_q [$];
    int unsigned errors;

    function void clear_all();
      foreach (dir_q[i]) dir_q[i] = '0;
      pool_q.delete();
      tables_used = 0;
      want_q.delete();
      errors = 0;
    endfunction

    // table number behind a virtual address, -1 when the directory is absent
    function int lookup_table(logic [31:0] va);
      logic [31:0] de;
      de = dir_q[va[31:22]];
      if (!de[FlagPresent] || de[31:12] >= PoolTablesDefault) return -1;
      return int'(de[31:12]);
    endfunction

    function void note(req_t r);
      rsp_t        p;
      int          t;
      logic [31:0] e, page, last;
      logic [63:0] room;
      p = '{status: StOk, phys_result: '0};
      t = lookup_table(r.virt_addr);
      case (r.operation)
        OpMap: begin
          if (t < 0) begin
            if (tables_used >= PoolTablesDefault) p.status = StPoolEmpty;
            else begin
              t = int'(tables_used);
              tables_used++;
              for (int i = 0; i < EntryCount; i++) pool_q[t * EntryCount + i] = '0;
              dir_q[r.virt_addr[31:22]] = {t[19:0], 9'd0, r.page_flags[FlagUser], 2'b11};
            end
          end
          if (p.status == StOk)
            pool_q[t * EntryCount + r.virt_addr[21:12]] =
              {r.phys_addr[31:12], r.page_flags};
        end
        OpUnmap: begin
          if (t < 0) p.status = StDirAbsent;
          else pool_q[t * EntryCount + r.virt_addr[21:12]] = '0;
        end
        OpTranslate: begin
          if (t < 0) p.status = StDirAbsent;
          else begin
            e = pool_q[t * EntryCount + r.virt_addr[21:12]];
            if (!e[FlagPresent]) p.status = StPgAbsent;
            else p.phys_result = {e[31:12], r.virt_addr[11:0]};
          end
        end
        default: begin
          room = 64'h1_0000_0000 - {32'd0, r.virt_addr};
          if (r.range_length == 0) p.status = StOk;
          else if ({32'd0, r.range_length} > room) p.status = StWraps;
          else begin
            page = {r.virt_addr[31:12], 12'd0};
            last = r.virt_addr + r.range_length - 32'd1;
            last[11:0] = '0;
            forever begin
              t = lookup_table(page);
              if (t < 0) begin p.status = StDirAbsent; break; end
              e = pool_q[t * EntryCount + page[21:12]];
              if (!e[FlagPresent]) begin p.status = StPgAbsent; break; end
              if (!e[FlagUser]) begin p.status = StNotUser; break; end
              if (page == last) break;
              page += 32'd4096;
            end
          end
        end
      endcase
      want_q.push_back(p);
    endfunction

    function void check(rsp_t got);
      rsp_t w;
      if (want_q.size() == 0) begin
        $error("unexpected response: status %0d phys %h", got.status, got.phys_result);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.status !== w.status) begin
        $error("status: expected %0d actual %0d", w.status, got.status);
        errors++;
      end
      if (got.phys_result !== w.phys_result) begin
        $error("phys_result: expected %h actual %h", w.phys_result, got.phys_result);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  req_t req_i;
  logic empty;
  logic pop;
  rsp_t rsp_o;

  pt_scoreboard sb;
  logic         quiet;   // no idling on either side while set
  logic [9:0]   hot_dir [NumHot];
  int unsigned  idle_cnt;

  two_level_page_table_engine_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // present a request and hold it until the engine takes the beat
  task automatic send(req_t r);
    if (!quiet && $urandom_range(99) < 27) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    sb.note(r);
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                         logic [11:0] fl, logic [31:0] len);
    req_t r;
    r = '{operation: op, virt_addr: va, phys_addr: pa, page_flags: fl,
          range_length: len};
    send(r);
  endtask

  function automatic logic [31:0] pick_va();
    logic [9:0] ti;
    if ($urandom_range(99) < 12) return $urandom;
    case ($urandom_range(9))
      0:       ti = 10'd0;
      1:       ti = 10'h3ff;
      2:       ti = 10'($urandom);
      default: ti = 10'($urandom_range(15));
    endcase
    return {hot_dir[$urandom_range(NumHot - 1)], ti, 12'($urandom)};
  endfunction

  function automatic req_t pick_req();
    req_t r;
    r.operation = 2'($urandom_range(3));
    r.virt_addr = pick_va();
    r.phys_addr = $urandom;
    r.page_flags = 12'($urandom);
    if ($urandom_range(99) < 70) r.page_flags[FlagPresent] = 1'b1;
    case ($urandom_range(19))
      0, 1, 2:    r.range_length = '0;
      3, 4, 5, 6: r.range_length = $urandom;
      default:    r.range_length = $urandom_range(1, 32'h6000);
    endcase
    return r;
  endfunction

  // response side: check every popped beat, then decide the next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check(rsp_o);
    pop <= quiet || ($urandom_range(99) >= 27);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cnt <= 0;
    else if (idle_cnt >= WdLimit) begin
      $display("** two_level_page_table_engine_core: FAILED **");
      $finish;
    end else idle_cnt <= idle_cnt + 1;
  end

  initial begin
    sb = new();
    sb.clear_all();
    rst_ni   = 1'b0;
    push     = 1'b0;
    req_i    = '0;
    quiet    = 1'b0;
    hot_dir[0] = 10'd0;
    hot_dir[1] = 10'h3ff;
    hot_dir[2] = 10'd1;
    for (int i = 3; i < NumHot; i++) hot_dir[i] = 10'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, wrap and boundary cases, flags extremes
    send_op(OpTranslate, 32'h0040_0123, '0, '0, '0);
    send_op(OpUnmap,     32'h0040_0000, '0, '0, '0);
    send_op(OpCheck,     32'h1234_5678, '0, '0, 32'd0);
    send_op(OpCheck,     32'hffff_f000, '0, '0, 32'h2000);
    send_op(OpCheck,     32'hffff_ffff, '0, '0, 32'd1);
    send_op(OpCheck,     32'h0000_0000, '0, '0, 32'hffff_ffff);
    send_op(OpMap,       32'h0040_0123, 32'hffff_ffff, 12'hfff, '0);
    send_op(OpTranslate, 32'h0040_0abc, '0, '0, '0);
    send_op(OpCheck,     32'h0040_0ff0, '0, '0, 32'h10);
    send_op(OpMap,       32'h0040_1000, 32'h8000_0000, 12'h001, '0);
    send_op(OpCheck,     32'h0040_0ff0, '0, '0, 32'h20);
    send_op(OpCheck,     32'h0040_1800, '0, '0, 32'h1000);
    send_op(OpTranslate, 32'h0040_2000, '0, '0, '0);
    send_op(OpMap,       32'h0040_3000, 32'h1234_5000, 12'h000, '0);
    send_op(OpTranslate, 32'h0040_3fff, '0, '0, '0);
    send_op(OpUnmap,     32'h0040_0000, '0, '0, '0);
    send_op(OpTranslate, 32'h0040_0000, '0, '0, '0);
    send_op(OpMap,       32'hffff_f000, 32'h0000_0fff, 12'h005, '0);
    send_op(OpTranslate, 32'hffff_ffff, '0, '0, '0);
    send_op(OpCheck,     32'hffff_f000, '0, '0, 32'h1000);
    send_op(OpMap,       32'h0000_0000, 32'h0000_0000, 12'h006, '0);
    send_op(OpCheck,     32'h0000_0000, '0, '0, 32'h1);

    // random: mostly hot directory slots so maps, walks and pool use build up
    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 800 && n < 1100);
      send(pick_req());
    end
    push  <= 1'b0;
    quiet = 1'b0;

    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("** two_level_page_table_engine_core: PASSED **");
    else $display("** two_level_page_table_engine_core: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_front.sv
rtl/core/tlpt_back.sv
rtl/core/two_level_page_table_engine_core.sv
test/tb.sv
